@@ rtl/frec_pkg.sv @@
// frec_pkg: shared types for the float relative equal compare unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package frec_pkg;

  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW  = 8;
  // guard, round and sticky below the fraction
  localparam int unsigned GrsW  = 3;
  // hidden bit, fraction, guard, round, sticky
  localparam int unsigned AlW   = FracW + 1 + GrsW;
  localparam int unsigned SumW  = AlW + 1;

  // status that travels with each item
  typedef struct packed {
    logic any_nan;
    logic any_inf;
    logic sub_nan;
  } frec_flags_t;

  // stage one result: aligned operands, magnitude larger first
  typedef struct packed {
    logic [ExpW-1:0]  exp_big;
    logic [AlW-1:0]   sig_big;
    logic [AlW-1:0]   sig_small;
    logic             eff_sub;
    logic [30:0]      mag_big;
    frec_flags_t      flags;
  } frec_align_t;

  // stage two result: raw sum and scaled bound
  typedef struct packed {
    logic [ExpW-1:0]  exp_big;
    logic [SumW-1:0]  sum;
    logic [30:0]      bound;
    frec_flags_t      flags;
  } frec_sum_t;

  // stage three result: normalised magnitude of the difference
  typedef struct packed {
    logic [30:0]      diff;
    logic [30:0]      bound;
    frec_flags_t      flags;
  } frec_norm_t;

endpackage
`default_nettype wire

@@ rtl/frec_align.sv @@
// frec_align: unpacks operands, orders magnitudes and aligns the smaller one
// depends on frec_pkg
`timescale 1ns / 1ps
`default_nettype none
module frec_align
  import frec_pkg::*;
(
  input  wire logic [31:0] first_value_i,
  input  wire logic [31:0] second_value_i,
  output frec_align_t      align_o
);

  logic [30:0]     mag_a, mag_b, mag_big, mag_small;
  logic            swap;
  logic [ExpW-1:0] e_big, e_small, e_big_eff, e_small_eff;
  logic [AlW-1:0]  s_big, s_small, shifted;
  logic [ExpW-1:0] shift_amt;
  logic            sticky;
  logic            nan_a, nan_b, inf_a, inf_b;

  always_comb begin
    mag_a = first_value_i[30:0];
    mag_b = second_value_i[30:0];
    nan_a = (mag_a[30:23] == 8'hFF) && (mag_a[22:0] != '0);
    nan_b = (mag_b[30:23] == 8'hFF) && (mag_b[22:0] != '0);
    inf_a = (mag_a[30:23] == 8'hFF) && (mag_a[22:0] == '0);
    inf_b = (mag_b[30:23] == 8'hFF) && (mag_b[22:0] == '0);
    // order by magnitude
    swap      = mag_b > mag_a;
    mag_big   = swap ? mag_b : mag_a;
    mag_small = swap ? mag_a : mag_b;
    e_big     = mag_big[30:23];
    e_small   = mag_small[30:23];
    // subnormals use exponent one with no hidden bit
    e_big_eff   = (e_big == '0) ? 8'd1 : e_big;
    e_small_eff = (e_small == '0) ? 8'd1 : e_small;
    s_big   = {(e_big != '0), mag_big[22:0], 3'b000};
    s_small = {(e_small != '0), mag_small[22:0], 3'b000};
    shift_amt = e_big_eff - e_small_eff;
    // alignment shift with sticky collection
    if (shift_amt >= 8'(AlW)) begin
      shifted = '0;
      sticky  = s_small != '0;
    end else begin
      shifted = s_small >> shift_amt;
      sticky  = (s_small & ((AlW'(1) << shift_amt) - AlW'(1))) != '0;
    end
    align_o.exp_big   = e_big_eff;
    align_o.sig_big   = s_big;
    align_o.sig_small = {shifted[AlW-1:1], shifted[0] | sticky};
    align_o.eff_sub   = first_value_i[31] == second_value_i[31];
    align_o.mag_big   = mag_big;
    align_o.flags.any_nan = nan_a | nan_b;
    align_o.flags.any_inf = inf_a | inf_b;
    align_o.flags.sub_nan = inf_a & inf_b & (first_value_i[31] == second_value_i[31]);
  end

endmodule
`default_nettype wire

@@ rtl/frec_addsub.sv @@
// frec_addsub: adds or subtracts the aligned significands, scales the bound
// depends on frec_pkg
`timescale 1ns / 1ps
`default_nettype none
module frec_addsub
  import frec_pkg::*;
(
  input  wire frec_align_t align_i,
  output frec_sum_t        sum_o
);

  logic [30:0] bound;
  logic [ExpW-1:0] e;
  logic [24:0] sig, shv;
  logic [4:0]  sh;
  logic        rb, st;

  // largest magnitude times 2^-23, round to nearest even
  always_comb begin
    e     = align_i.mag_big[30:23];
    sig   = {1'b0, (e != '0), align_i.mag_big[22:0]};
    bound = '0;
    sh    = '0;
    shv   = '0;
    rb    = 1'b0;
    st    = 1'b0;
    if (e == 8'hFF) begin
      bound = align_i.mag_big;
    end else if (e > 8'd23) begin
      bound = {e - 8'd23, align_i.mag_big[22:0]};
    end else begin
      // result subnormal: shift right by 24 - max(e,1)
      sh  = 5'(8'd24 - ((e == '0) ? 8'd1 : e));
      shv = sig >> sh;
      rb  = (sh == '0) ? 1'b0 : sig[sh - 5'd1];
      st  = (sh <= 5'd1) ? 1'b0 : ((sig & ((25'(1) << (sh - 5'd1)) - 25'(1))) != '0);
      bound = 31'(shv) + 31'(rb & (st | shv[0]));
    end
  end

  assign sum_o.exp_big = align_i.exp_big;
  assign sum_o.sum     = align_i.eff_sub ?
                         ({1'b0, align_i.sig_big} - {1'b0, align_i.sig_small}) :
                         ({1'b0, align_i.sig_big} + {1'b0, align_i.sig_small});
  assign sum_o.bound   = bound;
  assign sum_o.flags   = align_i.flags;

endmodule
`default_nettype wire

@@ rtl/frec_norm.sv @@
// frec_norm: normalises and rounds the difference magnitude
// depends on frec_pkg
`timescale 1ns / 1ps
`default_nettype none
module frec_norm
  import frec_pkg::*;
(
  input  wire frec_sum_t sum_i,
  output frec_norm_t     norm_o
);

  logic [4:0]      lz;
  logic            found;
  logic [SumW-1:0] m;
  logic [9:0]      e;
  logic [4:0]      lsh;
  logic [24:0]     rnd;
  logic            g, st;
  logic [9:0]      e_out;
  logic [30:0]     res;

  always_comb begin
    // leading one search, index from the top
    lz    = '0;
    found = 1'b0;
    lsh   = '0;
    for (int i = SumW - 1; i >= 0; i--) begin
      if (!found && sum_i.sum[i]) begin
        found = 1'b1;
        lz    = 5'(SumW - 1 - i);
      end
    end
    e = {2'b00, sum_i.exp_big};
    m = sum_i.sum;
    if (sum_i.sum[SumW-1]) begin
      // carry out: shift right one, keep sticky
      m = {1'b0, sum_i.sum[SumW-1:2], sum_i.sum[1] | sum_i.sum[0]};
      e = e + 10'd1;
    end else begin
      // left shift limited so the exponent stays at least one
      lsh = ((10'(lz) - 10'd1) < (e - 10'd1)) ? (lz - 5'd1) : 5'(e - 10'd1);
      if (lz == '0) lsh = '0;
      m = sum_i.sum << lsh;
      e = e - 10'(lsh);
    end
    // m[AlW-1] is the hidden bit, then fraction, guard, then round/sticky
    g   = m[2];
    st  = m[1] | m[0];
    rnd = {1'b0, m[AlW-1:3]} + 25'(g & (st | m[3]));
    e_out = e;
    if (rnd[24]) begin
      rnd   = rnd >> 1;
      e_out = e + 10'd1;
    end
    if (rnd[23] == 1'b0) e_out = '0;
    if (e_out >= 10'd255) res = {8'hFF, 23'd0};
    else res = {e_out[7:0], rnd[22:0]};
    if (!found) res = '0;
    norm_o.diff  = res;
    norm_o.bound = sum_i.bound;
    norm_o.flags = sum_i.flags;
  end

endmodule
`default_nettype wire

@@ rtl/float_relative_equal_compare_unit.sv @@
// float_relative_equal_compare_unit: pipelined relative near-equality test
// depends on frec_pkg, frec_align, frec_addsub, frec_norm
//
//   channel | valid   | stall   | payload
//   in      | valid_i | stall_o | first_value_i, second_value_i
//   out     | valid_o | stall_i | nearly_equal_o
//
// four register stages: align, add/subtract with bound, normalise/round, compare
// one item per cycle unless stalled; valid_o is registered with the result
// reset clears the stage valid bits only
// a stall holds the full run of stages at the output; empty stages keep filling
`timescale 1ns / 1ps
`default_nettype none
module float_relative_equal_compare_unit
  import frec_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] first_value_i,
  input  wire logic [31:0] second_value_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic             nearly_equal_o
);

  frec_align_t al_d, al_q;
  frec_sum_t   sm_d, sm_q;
  frec_norm_t  nm_d, nm_q;
  logic        v1_q, v2_q, v3_q, v4_q;
  logic        eq_d, eq_q;
  logic        en1, en2, en3, en4;

  frec_align  u_align  (.first_value_i, .second_value_i, .align_o(al_d));
  frec_addsub u_addsub (.align_i(al_q), .sum_o(sm_d));
  frec_norm   u_norm   (.sum_i(sm_q), .norm_o(nm_d));

  // stage enables: a stage moves when its successor can take it
  assign en4 = !v4_q || !stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign stall_o = !en1;

  // final compare, unordered gives zero
  always_comb begin
    if (nm_q.flags.any_nan || nm_q.flags.sub_nan) eq_d = 1'b0;
    else if (nm_q.flags.any_inf) eq_d = 1'b1;
    else eq_d = nm_q.diff <= nm_q.bound;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) al_q <= al_d;
    if (en2) sm_q <= sm_d;
    if (en3) nm_q <= nm_d;
    if (en4) eq_q <= eq_d;
  end

  assign valid_o        = v4_q;
  assign nearly_equal_o = eq_q;

endmodule
`default_nettype wire

@@ rtl/frec_checker.sv @@
// frec_checker: port level checks for the compare unit
// binds to float_relative_equal_compare_unit
`timescale 1ns / 1ps
`default_nettype none
module frec_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic valid_i,
  input wire logic stall_o,
  input wire logic valid_o,
  input wire logic stall_i,
  input wire logic nearly_equal_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(nearly_equal_o))
    else $error("result changed under stall");

  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !stall_o)
    else $error("input stalled while output empty");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without a stalled result");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && !stall_i ##1 !stall_i ##1 !stall_i ##1 !stall_i |=> valid_o)
    else $error("item lost in pipeline");

endmodule

bind float_relative_equal_compare_unit frec_checker u_frec_checker (
  .clk_i, .rst_ni, .valid_i, .stall_o, .valid_o, .stall_i, .nearly_equal_o
);
`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for float_relative_equal_compare_unit
// depends on the unit; predicts each answer from its own binary32 arithmetic
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam logic [31:0] PosInf  = 32'h7f80_0000;
  localparam logic [31:0] NegInf  = 32'hff80_0000;
  localparam logic [31:0] QuietNan = 32'h7fc0_0000;
  localparam logic [31:0] MaxNorm = 32'h7f7f_ffff;
  localparam logic [31:0] MinSub  = 32'h0000_0001;
  localparam logic [31:0] One     = 32'h3f80_0000;
  localparam int          NumRandom = 1230;
  localparam int          HoldCycles = 200;

  typedef struct {
    logic [31:0] first;
    logic [31:0] second;
    bit          typed;
    logic        answer;
  } pair_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] first_value_i = '0;
  logic [31:0] second_value_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic        nearly_equal_o;

  logic        answers_due[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          answers_seen = 0;
  int          answers_true = 0;
  bit          hold_wanted = 1'b0;
  bit          hold_done = 1'b0;
  bit          sending_done = 1'b0;

  float_relative_equal_compare_unit DUT (
    .clk_i, .rst_ni, .valid_i, .stall_o, .first_value_i, .second_value_i,
    .valid_o, .stall_i, .nearly_equal_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // binary32 pattern to real value, subnormals included
  function automatic real bits_to_value(logic [31:0] b);
    int  e;
    real m;
    e = int'(b[30:23]);
    if (e == 0) m = real'(b[22:0]) * (2.0 ** (-149));
    else m = real'({1'b1, b[22:0]}) * (2.0 ** (e - 150));
    return b[31] ? -m : m;
  endfunction

  // non-negative real rounded to binary32 bits, nearest even, overflow to infinity
  function automatic logic [31:0] round_to_single(real r);
    logic [63:0] d;
    logic [63:0] mant;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    int          fe;
    int          s;
    if (r == 0.0) return '0;
    d    = $realtobits(r);
    fe   = int'(d[62:52]) - 1023 + 127;
    mant = {11'd0, 1'b1, d[51:0]};
    s    = (fe >= 1) ? 29 : 30 - fe;
    if (s > 60) return '0;
    kept = mant >> s;
    rem  = mant & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (fe >= 1) begin
      bits = (64'(fe) << 23) + kept - (64'd1 << 23);
      if (bits >= 64'(PosInf)) return PosInf;
      return bits[31:0];
    end
    // subnormal: a carry lands on the smallest normal by itself
    return kept[31:0];
  endfunction

  // relative near-equality of two binary32 patterns
  function automatic logic near_equal(logic [31:0] a, logic [31:0] b);
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic [31:0] diff;
    logic [31:0] bound;
    logic [30:0] larger;
    real         delta;
    a_nan = (a[30:23] == 8'hff) && (a[22:0] != 0);
    b_nan = (b[30:23] == 8'hff) && (b[22:0] != 0);
    a_inf = (a[30:0] == PosInf[30:0]);
    b_inf = (b[30:0] == PosInf[30:0]);
    if (a_nan || b_nan) return 1'b0;
    if (a_inf && b_inf) return a[31] != b[31];
    if (a_inf || b_inf) return 1'b1;
    delta  = bits_to_value(a) - bits_to_value(b);
    diff   = round_to_single(delta < 0.0 ? -delta : delta);
    larger = (b[30:0] > a[30:0]) ? b[30:0] : a[30:0];
    bound  = round_to_single(bits_to_value({1'b0, larger}) * (2.0 ** (-23)));
    return diff <= bound;
  endfunction

  // random operand pair, often close neighbours so both answers appear
  task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
    logic [31:0] specials[8];
    int          pick;
    specials = '{PosInf, NegInf, QuietNan, 32'hffff_ffff, MaxNorm, MinSub,
                 32'h8000_0000, 32'h0000_0000};
    a    = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      b = a + 32'($urandom_range(0, 6)) - 32'd3;
      if ($urandom_range(0, 7) == 0) b[31] = ~b[31];
    end else if (pick < 65) begin
      b = $urandom;
    end else if (pick < 78) begin
      b = {a[31:23], 23'($urandom)};
    end else if (pick < 88) begin
      a = specials[$urandom_range(0, 7)];
      b = ($urandom_range(0, 1) == 1) ? specials[$urandom_range(0, 7)] : 32'($urandom);
      if ($urandom_range(0, 1) == 1) {a, b} = {b, a};
    end else begin
      a = {1'($urandom), 8'd0, 23'($urandom)};
      b = ($urandom_range(0, 1) == 1) ? a + 32'($urandom_range(0, 4)) - 32'd2
                                      : {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
    end
  endtask

  // offer one item and hold it until accepted
  task automatic send_pair(logic [31:0] a, logic [31:0] b);
    valid_i        <= 1'b1;
    first_value_i  <= a;
    second_value_i <= b;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // record the expected answer for every accepted item
  always @(posedge clk_i) begin
    if (rst_ni && valid_i && !stall_o) begin
      answers_due.push_back(near_equal(first_value_i, second_value_i));
    end
  end

  // compare each returned answer with the oldest one due
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && valid_o && !stall_i) begin
      answers_seen++;
      if (nearly_equal_o) answers_true++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer %b with none due", nearly_equal_o);
      end else begin
        want = answers_due.pop_front();
        if (nearly_equal_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer %0d: expected %b, got %b", answers_seen, want, nearly_equal_o);
        end
      end
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int held;
    @(posedge rst_ni);
    forever begin
      if (hold_wanted && !hold_done) begin
        held = 0;
        while (held < HoldCycles) begin
          stall_i <= 1'b1;
          @(posedge clk_i);
          held++;
        end
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(8, 64)) begin
        case (mode)
          0: stall_i <= 1'b0;
          1: stall_i <= ($urandom_range(0, 9) < 3);
          2: stall_i <= ~stall_i;
          default: stall_i <= ($urandom_range(0, 9) < 7);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // stimulus: directed rows, then random bursts
  initial begin
    pair_row_t   rows[$];
    logic [31:0] a;
    logic [31:0] b;
    int          gap;
    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1, 1'b1},
      '{32'h0000_0000, 32'h8000_0000, 1, 1'b1},
      '{One, One, 1, 1'b1},
      '{One, 32'h3f80_0001, 1, 1'b1},
      '{One, 32'h3f80_0002, 1, 1'b0},
      '{QuietNan, One, 1, 1'b0},
      '{One, 32'hffff_ffff, 1, 1'b0},
      '{QuietNan, QuietNan, 1, 1'b0},
      '{PosInf, One, 1, 1'b1},
      '{32'hc2c8_0000, NegInf, 1, 1'b1},
      '{PosInf, PosInf, 1, 1'b0},
      '{NegInf, NegInf, 1, 1'b0},
      '{PosInf, NegInf, 1, 1'b1},
      '{MaxNorm, 32'hff7f_ffff, 1, 1'b0},
      '{MaxNorm, MaxNorm, 1, 1'b1},
      '{MinSub, 32'h0000_0000, 1, 1'b0},
      '{MinSub, MinSub, 1, 1'b1},
      '{32'h007f_ffff, 32'h0080_0000, 0, 1'b0},
      '{32'h4b00_0000, 32'h4b00_0001, 0, 1'b0},
      '{32'hbf80_0000, 32'hbf7f_ffff, 0, 1'b0},
      '{One, 32'hbf80_0000, 0, 1'b0},
      '{32'h7f00_0000, 32'h7f00_0001, 0, 1'b0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows carry a typed answer where one is obvious
    foreach (rows[i]) begin
      if (rows[i].typed && near_equal(rows[i].first, rows[i].second) !== rows[i].answer) begin
        mismatches++;
        $display("row %0d: typed answer %b disagrees with prediction", i, rows[i].answer);
      end
      send_pair(rows[i].first, rows[i].second);
    end

    // random items in bursts; midway the receiver holds off while items keep coming
    while (items_sent < rows.size() + NumRandom) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 20)) begin
        if (items_sent == 600) hold_wanted = 1'b1;
        random_pair(a, b);
        send_pair(a, b);
      end
    end
    valid_i <= 1'b0;
    sending_done = 1'b1;
  end

  // end of run: drain, then report
  initial begin
    wait (sending_done);
    while (answers_seen < items_sent) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("sent %0d operand pairs, checked %0d answers (%0d near-equal)",
             items_sent, answers_seen, answers_true);
    $display("long receiver hold-off exercised: %0d, mismatches: %0d", hold_done, mismatches);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("float_relative_equal_compare_unit verification clean");
    end else begin
      $display("float_relative_equal_compare_unit verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("float_relative_equal_compare_unit verification failed");
    $finish;
  end

endmodule
`default_nettype wire
